// ===== hw/rtl/sik_pkg.sv =====
// Shared types, constants and helpers for the Stokeslet/stresslet image kernel.
// No dependencies; imported by every module of the block except sik_div.
package sik_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int GREEN_SHIFT     = 60 - COORD_FRAC_BITS;
    localparam int STRESS_SHIFT    = 90 - 2 * COORD_FRAC_BITS;

    localparam logic [31:0] GREEN_SCALE  = 32'd170891319;
    localparam logic [31:0] STRESS_SCALE = 32'd1025347913;

    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

    localparam logic [1:0] REG_WALL_AXIS = 2'd0;
    localparam logic [1:0] REG_EPS       = 2'd1;
    localparam logic [1:0] REG_SIGN_RULE = 2'd2;

    localparam logic [1:0] RULE_ROW = 2'd0;
    localparam logic [1:0] RULE_COL = 2'd1;
    localparam logic [1:0] RULE_OLD = 2'd2;

    typedef struct packed {
        logic        command;
        logic [31:0] sep_x;
        logic [31:0] sep_y;
        logic [31:0] sep_z;
        logic [31:0] image_x;
        logic [31:0] image_y;
        logic [31:0] image_z;
    } item_t;

    typedef struct packed {
        logic [63:0] entry_value;
        logic [1:0]  row_index;
        logic [1:0]  col_index;
        logic [1:0]  depth_index;
        logic        saturated;
        logic        last_entry;
    } result_t;

    typedef struct packed {
        logic [1:0]  wall_axis;
        logic [30:0] regularization;
        logic [1:0]  sign_rule;
    } cfg_t;

    // one prepared item: lengths, Q.30 cosine magnitudes and signs per vector
    typedef struct packed {
        logic                   command;
        logic                   bad;
        logic [1:0][32:0]       r;
        logic [1:0][2:0][30:0]  cm;
        logic [1:0][2:0]        cn;
    } rec_t;

    typedef enum logic [2:0] {
        F_IDLE, F_SQ, F_SQRT, F_DSTART, F_DWAIT, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_START, B_MUL, B_DSTART, B_DWAIT, B_EMIT
    } back_state_t;

    function automatic logic image_minus(input logic [1:0] rule, input logic [1:0] axis,
                                         input logic [1:0] i, input logic [1:0] j,
                                         input logic [1:0] k, input logic stress);
        logic res;
        case (rule)
            RULE_ROW: res = (i == axis);
            RULE_COL: res = (j == axis);
            RULE_OLD: res = stress ? ((j == axis) != (k == axis)) : (j == axis);
            default:  res = stress ? ((j == axis) != (k == axis)) : (j == axis);
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/sik_div.sv =====
// Restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per cycle.
// Depends on nothing; used by sik_front and sik_back.
module sik_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [32:0] dvs_reg;
    logic [63:0] quo_reg;
    logic [33:0] rem_sh;
    logic [33:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_reg, quo_reg[63]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[32:0] : rem_sh[32:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/sik_front.sv =====
// Front end: takes a word, forms regularized lengths and Q.30 cosines of both vectors.
// Depends on sik_pkg and sik_div.
module sik_front
    import sik_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_data,
    input  cfg_t  cfg,
    input  logic  q_full,
    output logic  q_push,
    output rec_t  q_data
);

    front_state_t state_reg, state_next;

    logic                  cmd_reg;
    logic                  vsel_reg;
    logic [4:0]            cnt_reg;
    logic [1:0][2:0][31:0] mag_reg;
    logic [1:0][2:0]       cn_reg;
    logic [63:0]           sum_reg;
    logic [63:0]           res_reg;
    logic [1:0][32:0]      r_reg;
    logic [1:0][2:0][30:0] cm_reg;

    logic [31:0] raw [2][3];
    logic [31:0] cur_mag;
    logic [63:0] sq;
    logic [63:0] sum_next;
    logic [5:0]  bit_pos;
    logic [63:0] bit_val;
    logic [63:0] trial;
    logic        take;
    logic [63:0] res_next;
    logic [32:0] len;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_q;
    logic        accept;

    assign raw[0][0] = in_data.sep_x;
    assign raw[0][1] = in_data.sep_y;
    assign raw[0][2] = in_data.sep_z;
    assign raw[1][0] = in_data.image_x;
    assign raw[1][1] = in_data.image_y;
    assign raw[1][2] = in_data.image_z;

    assign cur_mag  = mag_reg[vsel_reg][cnt_reg[1:0]];
    assign sq       = 64'(cur_mag) * 64'(cur_mag);
    assign sum_next = sum_reg + sq;
    assign bit_pos  = 6'd62 - {cnt_reg, 1'b0};
    assign bit_val  = 64'd1 << bit_pos;
    assign trial    = res_reg + bit_val;
    assign take     = sum_reg >= trial;
    assign res_next = take ? ((res_reg >> 1) + bit_val) : (res_reg >> 1);
    assign len      = {1'b0, res_next[31:0]} + {2'b0, cfg.regularization};
    assign accept   = in_valid && (state_reg == F_IDLE);

    sik_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({2'b0, cur_mag, 30'b0}),
        .divisor  (r_reg[vsel_reg]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:   if (in_valid) state_next = F_SQ;
            F_SQ:     if (cnt_reg == 5'd2) state_next = F_SQRT;
            F_SQRT:   if (cnt_reg == 5'd31) state_next = F_DSTART;
            F_DSTART: state_next = F_DWAIT;
            F_DWAIT:
            begin
                if (div_done)
                begin
                    if (cnt_reg != 5'd2)
                        state_next = F_DSTART;
                    else if (!vsel_reg)
                        state_next = F_SQ;
                    else
                        state_next = F_PUSH;
                end
            end
            F_PUSH:   if (!q_full) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != F_IDLE);
        div_start = (state_reg == F_DSTART);
        q_push    = (state_reg == F_PUSH) && !q_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            vsel_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                F_IDLE:
                begin
                    vsel_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                F_SQ:     cnt_reg <= (cnt_reg == 5'd2) ? 5'd0 : cnt_reg + 5'd1;
                F_SQRT:   cnt_reg <= cnt_reg + 5'd1;
                F_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (cnt_reg != 5'd2)
                            cnt_reg <= cnt_reg + 5'd1;
                        else
                        begin
                            cnt_reg  <= '0;
                            vsel_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_data.command;
            sum_reg <= '0;
            for (int v = 0; v < 2; v++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    cn_reg[v][c]  <= raw[v][c][31];
                    mag_reg[v][c] <= raw[v][c][31] ? (32'd0 - raw[v][c]) : raw[v][c];
                end
            end
        end
        case (state_reg)
            F_SQ:
            begin
                sum_reg <= sum_next;
                res_reg <= '0;
            end
            F_SQRT:
            begin
                if (take)
                    sum_reg <= sum_reg - trial;
                res_reg <= res_next;
                if (cnt_reg == 5'd31)
                    r_reg[vsel_reg] <= len;
            end
            F_DWAIT:
            begin
                if (div_done)
                begin
                    cm_reg[vsel_reg][cnt_reg[1:0]] <=
                        (r_reg[vsel_reg] != 33'd0) ? div_q[30:0] : 31'd0;
                    sum_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        q_data.command = cmd_reg;
        q_data.bad     = (r_reg[0] == 33'd0) || (r_reg[1] == 33'd0);
        q_data.r       = r_reg;
        q_data.cm      = cm_reg;
        q_data.cn      = cn_reg;
    end

endmodule

// ===== hw/rtl/sik_fifo.sv =====
// Two-entry queue of prepared items between front and back ends.
// Depends on sik_pkg.
module sik_fifo
    import sik_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output rec_t head
);

    rec_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/sik_back.sv =====
// Back end: walks tensor entries, forms both terms with a chunked multiplier and the
// divider, combines with the image sign and saturates. Depends on sik_pkg and sik_div.
module sik_back
    import sik_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  rec_t    head,
    output logic    pop,
    input  cfg_t    cfg,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    back_state_t state_reg, state_next;

    logic [1:0]         i_reg, j_reg, k_reg;
    logic               vsel_reg;
    logic [1:0]         phase_reg;
    logic [1:0]         mcnt_reg;
    logic               pass_reg;
    logic [127:0]       x_reg;
    logic [127:0]       acc_reg;
    logic [63:0]        dvd_reg;
    logic signed [64:0] a_reg;
    logic [63:0]        val_reg;
    logic               sat_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;

    logic               stress;
    logic [1:0]         kmax;
    logic [1:0]         last_phase;
    logic [30:0]        cm_i, cm_j, cm_k;
    logic               cn_i, cn_j, cn_k;
    logic [31:0]        y_op;
    logic [31:0]        chunk;
    logic [63:0]        prod;
    logic [127:0]       acc_next;
    logic [127:0]       bump;
    logic [127:0]       g_sh, s_sh;
    logic               neg_t;
    logic               minus;
    logic               div_start;
    logic               div_done;
    logic [63:0]        div_q;
    logic signed [64:0] term_pos;
    logic signed [64:0] term_a;
    logic signed [64:0] term_b;
    logic signed [64:0] sum;
    logic               last;
    logic               out_free;
    logic               out_load;

    assign stress     = head.command;
    assign kmax       = stress ? 2'd2 : 2'd0;
    assign last_phase = stress ? 2'd2 : 2'd1;
    assign cm_i = head.cm[vsel_reg][i_reg];
    assign cm_j = head.cm[vsel_reg][j_reg];
    assign cm_k = head.cm[vsel_reg][k_reg];
    assign cn_i = head.cn[vsel_reg][i_reg];
    assign cn_j = head.cn[vsel_reg][j_reg];
    assign cn_k = head.cn[vsel_reg][k_reg];

    always_comb
    begin
        case (phase_reg)
            2'd0:    y_op = {1'b0, cm_j};
            2'd1:    y_op = stress ? {1'b0, cm_k} : GREEN_SCALE;
            default: y_op = STRESS_SCALE;
        endcase
        case (mcnt_reg)
            2'd0:    chunk = x_reg[31:0];
            2'd1:    chunk = x_reg[63:32];
            2'd2:    chunk = x_reg[95:64];
            default: chunk = x_reg[127:96];
        endcase
    end

    assign prod     = 64'(chunk) * 64'(y_op);
    assign acc_next = acc_reg + ({64'd0, prod} << {mcnt_reg, 5'd0});
    assign bump     = (phase_reg == 2'd0 && !stress && i_reg == j_reg) ?
                      (128'd1 << 60) : 128'd0;
    assign g_sh     = acc_next >> GREEN_SHIFT;
    assign s_sh     = acc_next >> STRESS_SHIFT;

    assign neg_t    = stress ? ~(cn_i ^ cn_j ^ cn_k) : (cn_i ^ cn_j);
    assign minus    = image_minus(cfg.sign_rule, cfg.wall_axis, i_reg, j_reg, k_reg, stress);
    assign term_pos = $signed({1'b0, div_q});
    assign term_a   = neg_t ? -term_pos : term_pos;
    assign term_b   = (neg_t ^ minus) ? -term_pos : term_pos;
    assign sum      = a_reg + term_b;

    assign last     = (i_reg == 2'd2) && (j_reg == 2'd2) && (k_reg == kmax);
    assign out_free = !out_valid_reg || !out_stall;

    sik_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (head.r[vsel_reg]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (head_valid)
                    state_next = head.bad ? B_EMIT : B_START;
            B_START:  state_next = B_MUL;
            B_MUL:
                if (mcnt_reg == 2'd3 && phase_reg == last_phase)
                    state_next = B_DSTART;
            B_DSTART: state_next = B_DWAIT;
            B_DWAIT:
            begin
                if (div_done)
                begin
                    if (stress && !pass_reg)
                        state_next = B_DSTART;
                    else if (!vsel_reg)
                        state_next = B_START;
                    else
                        state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    if (last)
                        state_next = B_IDLE;
                    else
                        state_next = head.bad ? B_EMIT : B_START;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = (state_reg == B_DSTART);
        out_load  = (state_reg == B_EMIT) && out_free;
        pop       = out_load && last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            vsel_reg      <= 1'b0;
            phase_reg     <= '0;
            mcnt_reg      <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_START:
                begin
                    phase_reg <= '0;
                    mcnt_reg  <= '0;
                end
                B_MUL:
                begin
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3)
                    begin
                        phase_reg <= phase_reg + 2'd1;
                        pass_reg  <= 1'b0;
                    end
                end
                B_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (stress && !pass_reg)
                            pass_reg <= 1'b1;
                        else
                            vsel_reg <= ~vsel_reg;
                    end
                end
                B_EMIT:
                begin
                    if (out_free)
                    begin
                        if (k_reg != kmax)
                            k_reg <= k_reg + 2'd1;
                        else
                        begin
                            k_reg <= '0;
                            if (j_reg != 2'd2)
                                j_reg <= j_reg + 2'd1;
                            else
                            begin
                                j_reg <= '0;
                                i_reg <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_START:
            begin
                x_reg   <= {97'd0, cm_i};
                acc_reg <= '0;
            end
            B_MUL:
            begin
                if (mcnt_reg == 2'd3)
                begin
                    acc_reg <= '0;
                    x_reg   <= acc_next + bump;
                    dvd_reg <= stress ? s_sh[63:0] : g_sh[63:0];
                end
                else
                    acc_reg <= acc_next;
            end
            B_DWAIT:
            begin
                if (div_done)
                begin
                    if (stress && !pass_reg)
                        dvd_reg <= div_q;
                    else if (!vsel_reg)
                        a_reg <= term_a;
                    else
                    begin
                        sat_reg <= (sum[64] != sum[63]);
                        if (sum[64] != sum[63])
                            val_reg <= sum[64] ? VAL_MIN : VAL_MAX;
                        else
                            val_reg <= sum[63:0];
                    end
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_data_reg.entry_value <= head.bad ? 64'd0 : val_reg;
            out_data_reg.saturated   <= head.bad ? 1'b1 : sat_reg;
            out_data_reg.row_index   <= i_reg;
            out_data_reg.col_index   <= j_reg;
            out_data_reg.depth_index <= k_reg;
            out_data_reg.last_entry  <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/stokeslet_image_kernel_top.sv =====
// Top level: configuration registers, front end, queue and back end.
// Depends on sik_pkg, sik_front, sik_fifo, sik_back.
// Front end: two square roots and six 64-step divides per word.
// Back end: one 64-step divide per term of a G entry, two per term of a W entry.
// Throughput is set by the back-end divider. Reset clears control state and the
// configuration registers; datapath registers are loaded before use.
module stokeslet_image_kernel_top
    import sik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  item_t       in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output result_t     out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  wall_axis_reg;
    logic [30:0] eps_reg;
    logic [1:0]  sign_rule_reg;
    cfg_t        cfg;
    logic        wr_en;
    logic        q_full, q_push, q_pop, q_valid;
    rec_t        q_in, q_head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_axis_reg <= '0;
            eps_reg       <= '0;
            sign_rule_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_WALL_AXIS: wall_axis_reg <= pwdata[1:0];
                REG_EPS:       eps_reg       <= pwdata[30:0];
                REG_SIGN_RULE: sign_rule_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WALL_AXIS: prdata = {30'd0, wall_axis_reg};
            REG_EPS:       prdata = {1'b0, eps_reg};
            REG_SIGN_RULE: prdata = {30'd0, sign_rule_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.wall_axis      = wall_axis_reg;
    assign cfg.regularization = eps_reg;
    assign cfg.sign_rule      = sign_rule_reg;

    sik_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    sik_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    sik_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .cfg        (cfg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ===== hw/rtl/sik_check.sv =====
// Port-level checker for the kernel top, attached by bind.
// Depends on sik_pkg.
module sik_check
    import sik_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_stall,
    input result_t out_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.row_index != 2'd3 && out_data.col_index != 2'd3
                      && out_data.depth_index != 2'd3)
        else $error("tensor index out of range");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |-> out_data.entry_value == 64'd0
            || out_data.entry_value == VAL_MAX || out_data.entry_value == VAL_MIN)
        else $error("saturated word has non-extreme value");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_entry |-> out_data.row_index == 2'd2
                                           && out_data.col_index == 2'd2)
        else $error("last word not at final row and column");

endmodule

bind stokeslet_image_kernel_top sik_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== sim/stokeslet_image_kernel_top_tb.sv =====
// Self-checking testbench for stokeslet_image_kernel_top: predicts every G/W entry
// in wide integer arithmetic and compares it with the result words. Depends on sik_pkg.
module stokeslet_image_kernel_top_tb;
    import sik_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct {
        logic [63:0] len;
        logic [63:0] cosm [3];
        logic        cneg [3];
    } vec_info_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    item_t       in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    result_t     out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cfg_t    shadow_cfg = '0;
    item_t   word_q [$];
    result_t entry_q [$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      mismatches = 0;
    int      idle_cycles = 0;

    stokeslet_image_kernel_top dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic vec_info_t vec_info(input logic [31:0] c0, input logic [31:0] c1,
                                           input logic [31:0] c2);
        vec_info_t v;
        logic [63:0] mag [3];
        logic [31:0] raw [3];
        logic [63:0] sum;
        raw[0] = c0;
        raw[1] = c1;
        raw[2] = c2;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            v.cneg[i] = raw[i][31];
            mag[i] = raw[i][31] ? (64'd1 << 32) - {32'd0, raw[i]} : {32'd0, raw[i]};
            sum = sum + mag[i] * mag[i];
        end
        v.len = int_sqrt(sum) + {33'd0, shadow_cfg.regularization};
        for (int i = 0; i < 3; i++)
            v.cosm[i] = (v.len != 0) ? (mag[i] << 30) / v.len : 64'd0;
        return v;
    endfunction

    function automatic logic [127:0] green_val(input vec_info_t v, input int i, input int j);
        logic [63:0]  m;
        logic [127:0] w;
        m = v.cosm[i] * v.cosm[j];
        if (i == j)
            m = m + (64'd1 << 60);
        w = (128'(m) * 128'(GREEN_SCALE)) >> GREEN_SHIFT;
        w = w / 128'(v.len);
        return (v.cneg[i] != v.cneg[j]) ? -w : w;
    endfunction

    function automatic logic [127:0] stress_val(input vec_info_t v, input int i, input int j,
                                                input int k);
        logic [63:0]  p;
        logic [127:0] w;
        p = v.cosm[i] * v.cosm[j];
        w = 128'(p) * 128'(v.cosm[k]);
        w = (w * 128'(STRESS_SCALE)) >> STRESS_SHIFT;
        w = w / 128'(v.len);
        w = w / 128'(v.len);
        return !(v.cneg[i] ^ v.cneg[j] ^ v.cneg[k]) ? -w : w;
    endfunction

    function automatic logic subtracts_image(input int i, input int j, input int k,
                                             input logic stress);
        logic [1:0] ax;
        ax = shadow_cfg.wall_axis;
        if (shadow_cfg.sign_rule == RULE_ROW)
            return i == ax;
        if (shadow_cfg.sign_rule == RULE_COL)
            return j == ax;
        if (stress)
            return (j == ax) != (k == ax);
        return j == ax;
    endfunction

    function automatic void predict_tensor(input item_t it);
        vec_info_t   sv, iv;
        logic        bad;
        logic [127:0] a, b, s;
        logic [63:0] ext;
        result_t     e;
        int          kmax, n, total;
        sv = vec_info(it.sep_x, it.sep_y, it.sep_z);
        iv = vec_info(it.image_x, it.image_y, it.image_z);
        bad = (sv.len == 0) || (iv.len == 0);
        kmax = it.command ? 3 : 1;
        total = it.command ? 27 : 9;
        n = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < kmax; k++)
                begin
                    e = '0;
                    e.saturated = 1'b1;
                    if (!bad) begin
                        a = it.command ? stress_val(sv, i, j, k) : green_val(sv, i, j);
                        b = it.command ? stress_val(iv, i, j, k) : green_val(iv, i, j);
                        s = subtracts_image(i, j, k, it.command) ? a - b : a + b;
                        ext = s[63] ? '1 : '0;
                        if (s[127:64] == ext) begin
                            e.entry_value = s[63:0];
                            e.saturated = 1'b0;
                        end else begin
                            e.entry_value = s[127] ? VAL_MIN : VAL_MAX;
                        end
                    end
                    n++;
                    e.row_index = 2'(i);
                    e.col_index = 2'(j);
                    e.depth_index = 2'(k);
                    e.last_entry = (n == total);
                    entry_q.push_back(e);
                end
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 6))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 18)
                                           : -$urandom_range(0, 1 << 18);
            2: return 32'd0;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 24)
                                           : -$urandom_range(0, 1 << 24);
            default: return $urandom_range(0, 3) - 1;
        endcase
    endfunction

    function automatic item_t make_word(input logic cmd, input logic [31:0] sx,
                                        input logic [31:0] sy, input logic [31:0] sz,
                                        input logic [31:0] ix, input logic [31:0] iy,
                                        input logic [31:0] iz);
        item_t it;
        it.command = cmd;
        it.sep_x = sx;
        it.sep_y = sy;
        it.sep_z = sz;
        it.image_x = ix;
        it.image_y = iy;
        it.image_z = iz;
        return it;
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WALL_AXIS: shadow_cfg.wall_axis = value[1:0];
            REG_EPS:       shadow_cfg.regularization = value[30:0];
            REG_SIGN_RULE: shadow_cfg.sign_rule = value[1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (word_q.size() != 0 || in_valid || entry_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [1:0] ax, input logic [31:0] eps,
                            input logic [1:0] rule);
        wait_drained();
        apb_write(REG_WALL_AXIS, {30'd0, ax});
        apb_write(REG_EPS, eps);
        apb_write(REG_SIGN_RULE, {30'd0, rule});
    endtask

    // sender
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            predict_tensor(in_data);
        if (!in_valid || !in_stall) begin
            if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_data <= word_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        result_t e;
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (out_valid && !out_stall) begin
            if (entry_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", out_data);
            end else begin
                e = entry_q.pop_front();
                if (out_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", e, out_data);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (word_q.size() == 0 && entry_q.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [1:0]  ax [5];
        logic [31:0] eps [5];
        logic [1:0]  rule [5];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 80;

        // directed words, default registers
        word_q.push_back(make_word(1'b0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0));
        word_q.push_back(make_word(1'b1, 32'h0001_0000, 0, 0, 0, 32'h0002_0000, 0));
        word_q.push_back(make_word(1'b0, 0, 0, 0, 32'h0001_0000, 0, 0));
        word_q.push_back(make_word(1'b1, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0));
        word_q.push_back(make_word(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        word_q.push_back(make_word(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        word_q.push_back(make_word(1'b0, 1, 0, 0, 0, 1, 0));
        word_q.push_back(make_word(1'b1, 1, 1, 1, -1, -1, -1));
        word_q.push_back(make_word(1'b1, -1, 2, -3, 3, -2, 1));
        word_q.push_back(make_word(1'b0, 32'h0003_0000, 32'hFFFC_0000, 32'h0005_0000,
                                   32'h0003_0000, 32'hFFFC_0000, 32'hFFFB_0000));
        word_q.push_back(make_word(1'b1, 32'h0003_0000, 32'hFFFC_0000, 32'h0005_0000,
                                   32'h0003_0000, 32'hFFFC_0000, 32'hFFFB_0000));
        word_q.push_back(make_word(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                                   32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC));

        // unused register index, then every sign rule and wall axis incl. unused codes
        set_regs(2'd1, 32'h0000_8000, RULE_COL);
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        word_q.push_back(make_word(1'b1, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(1'b0, 0, 0, 0, 32'h0001_0000, 0, 0));
        word_q.push_back(make_word(1'b1, 32'h0002_0000, 32'h0001_0000, 32'h0004_0000,
                                   32'h0002_0000, 32'h0001_0000, 32'hFFFC_0000));
        set_regs(2'd3, 32'd0, 2'd3);
        word_q.push_back(make_word(1'b1, 32'h0002_0000, 32'h0001_0000, 32'h0004_0000,
                                   32'h0002_0000, 32'h0001_0000, 32'hFFFC_0000));
        word_q.push_back(make_word(1'b0, 32'h0002_0000, 32'h0001_0000, 32'h0004_0000,
                                   32'h0002_0000, 32'h0001_0000, 32'hFFFC_0000));

        ax[0] = 2'd2; eps[0] = 32'h7FFF_FFFF; rule[0] = RULE_OLD;
        ax[1] = 2'd0; eps[1] = 32'd0;         rule[1] = RULE_ROW;
        ax[2] = 2'd1; eps[2] = 32'h0001_0000; rule[2] = RULE_COL;
        ax[3] = 2'd3; eps[3] = $urandom();    rule[3] = 2'd3;
        ax[4] = 2'd2; eps[4] = $urandom_range(0, 1 << 20); rule[4] = RULE_OLD;
        for (int p = 0; p < 5; p++)
        begin
            set_regs(ax[p], eps[p], rule[p]);
            if (p == 2) begin
                send_idle_pct = 80;
                recv_idle_pct = 37;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 20; n++)
                word_q.push_back(make_word($urandom_range(0, 9) < 3, rand_coord(),
                                           rand_coord(), rand_coord(), rand_coord(),
                                           rand_coord(), rand_coord()));
        end

        wait_drained();
        if (mismatches == 0 && entry_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== stokeslet_image_kernel_top.f =====
hw/rtl/sik_pkg.sv
hw/rtl/sik_div.sv
hw/rtl/sik_front.sv
hw/rtl/sik_fifo.sv
hw/rtl/sik_back.sv
hw/rtl/stokeslet_image_kernel_top.sv
hw/rtl/sik_check.sv
sim/stokeslet_image_kernel_top_tb.sv
